[sv/oes_pkg.sv]
// Package for the obstacle escape sequencer.
// Holds register indexes, reset values, the phase type and the register bundle.
// No dependencies.
package oes_pkg;

	localparam int DISTANCE_BITS_DEF = 16;
	localparam int RANGE_W = 16;
	localparam int VEL_W = 16;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int SPEED_W = 15;
	localparam int TICK_W = 16;
	localparam int M_TDATA_W = 40;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_BUMP_DIST  = 3'd0,
		REG_ROBOT_SIZE = 3'd1,
		REG_RANGE_MIN  = 3'd2,
		REG_RANGE_MAX  = 3'd3,
		REG_BACK_TICKS = 3'd4,
		REG_BACK_SPEED = 3'd5,
		REG_TURN_TICKS = 3'd6,
		REG_TURN_RATE  = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_BACKOFF = 2'd1,
		PH_TURN    = 2'd2
	} phase_t;

	typedef struct packed {
		logic [RANGE_W-1:0]       bump_distance_mm;
		logic [RANGE_W-1:0]       robot_size_mm;
		logic [RANGE_W-1:0]       range_min_mm;
		logic [RANGE_W-1:0]       range_max_mm;
		logic [TICK_W-1:0]        backoff_ticks;
		logic [SPEED_W-1:0]       backoff_speed;
		logic [TICK_W-1:0]        turn_ticks;
		logic signed [VEL_W-1:0]  turn_rate;
	} cfg_regs_t;

	localparam logic [RANGE_W-1:0] RST_BUMP_DIST  = 16'd1000;
	localparam logic [RANGE_W-1:0] RST_ROBOT_SIZE = 16'd330;
	localparam logic [RANGE_W-1:0] RST_RANGE_MIN  = 16'd0;
	localparam logic [RANGE_W-1:0] RST_RANGE_MAX  = 16'd65535;
	localparam logic [TICK_W-1:0]  RST_BACK_TICKS = 16'd50;
	localparam logic [SPEED_W-1:0] RST_BACK_SPEED = 15'd500;
	localparam logic [TICK_W-1:0]  RST_TURN_TICKS = 16'd50;
	localparam logic [VEL_W-1:0]   RST_TURN_RATE  = 16'd1500;

endpackage

[sv/obstacle_escape_sequencer.sv]
// Obstacle escape sequencer: scan minimum tracker and backoff/turn phase sequencer.
// Depends on oes_pkg and oes_regs.
// A tick beat passes the input register, then the result register, to reach the output.
// Throughput: one beat per cycle; a tick beat waits while an untaken result is held.
// Range beats give no output beat. Reset clears the phase, counters, scan state
// and loads the configuration registers with their default values.
module obstacle_escape_sequencer #(
	parameter int DISTANCE_BITS = oes_pkg::DISTANCE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [15:0]                    s_tdata,   // [15:0] range_mm
	input  logic                           s_tuser,   // [0] mode (0 range, 1 tick)
	input  logic                           s_tlast,   // scan_end
	// output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [oes_pkg::M_TDATA_W-1:0]  m_tdata,   // [15:0] linear_vel, [31:16] angular_vel,
	                                                   // [33:32] phase, rest zero
	output logic                           m_tuser,   // [0] drive_valid
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [oes_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [oes_pkg::CFG_DATA_W-1:0] cfg_data
);
	import oes_pkg::*;

	localparam int DW = DISTANCE_BITS;

	cfg_regs_t regs;

	assign cfg_ready = 1'b1;

	oes_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_addr (cfg_addr),
		.wr_data (cfg_data),
		.regs    (regs)
	);

	// input register
	logic               valid_s1;
	logic               mode_s1;
	logic [RANGE_W-1:0] range_s1;
	logic               last_s1;

	// scan and sequencer state
	logic [DW-1:0]      running_min_q;
	logic               scan_open_q;
	logic [DW-1:0]      closest_q;
	logic               scan_seen_q;
	phase_t             phase_q;
	logic [TICK_W-1:0]  ticks_left_q;

	// result register
	logic               out_valid_q;
	logic               out_drive_q;
	logic [VEL_W-1:0]   out_lin_q;
	logic [VEL_W-1:0]   out_ang_q;
	phase_t             out_phase_q;

	logic out_free;
	logic go_s1;
	logic tick_go;
	logic samp_go;

	assign out_free = !out_valid_q || m_tready;
	assign go_s1    = valid_s1 && (!mode_s1 || out_free);
	assign tick_go  = go_s1 && mode_s1;
	assign samp_go  = go_s1 && !mode_s1;
	assign s_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1  <= s_tuser;
			range_s1 <= s_tdata;
			last_s1  <= s_tlast;
		end
	end

	// range sample path
	logic [DW-1:0] r_d;
	logic [DW-1:0] start_min;
	logic [DW-1:0] new_min;
	logic          take;

	always_comb begin
		r_d       = DW'(range_s1);
		start_min = scan_open_q ? running_min_q : DW'(regs.range_max_mm);
		take      = (r_d > DW'(regs.range_min_mm)) && (r_d > DW'(regs.robot_size_mm))
			&& (r_d < start_min);
		new_min   = take ? r_d : start_min;
	end

	// tick path
	phase_t            phase_d;
	logic [TICK_W-1:0] ticks_d;
	logic              drive_d;
	logic [VEL_W-1:0]  lin_d;
	logic [VEL_W-1:0]  ang_d;
	logic              more;

	always_comb begin
		phase_d = phase_q;
		ticks_d = ticks_left_q;
		drive_d = 1'b0;
		lin_d   = '0;
		ang_d   = '0;
		more    = ticks_left_q > TICK_W'(1);
		case (phase_q)
			PH_BACKOFF: begin
				if (more) begin
					ticks_d = ticks_left_q - TICK_W'(1);
					drive_d = 1'b1;
					lin_d   = VEL_W'(0) - {1'b0, regs.backoff_speed};
				end else begin
					phase_d = PH_TURN;
					ticks_d = regs.turn_ticks;
				end
			end
			PH_TURN: begin
				if (more) begin
					ticks_d = ticks_left_q - TICK_W'(1);
					drive_d = 1'b1;
					ang_d   = regs.turn_rate;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				// idle, and the unused code behaves as idle
				phase_d = PH_IDLE;
				if (scan_seen_q && (closest_q < DW'(regs.bump_distance_mm))) begin
					phase_d = PH_BACKOFF;
					ticks_d = regs.backoff_ticks;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_min_q <= '0;
			scan_open_q   <= 1'b0;
			closest_q     <= '0;
			scan_seen_q   <= 1'b0;
			phase_q       <= PH_IDLE;
			ticks_left_q  <= '0;
		end else begin
			if (samp_go) begin
				running_min_q <= new_min;
				scan_open_q   <= !last_s1;
				if (last_s1) begin
					closest_q   <= new_min;
					scan_seen_q <= 1'b1;
				end
			end
			if (tick_go) begin
				phase_q      <= phase_d;
				ticks_left_q <= ticks_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			out_drive_q <= drive_d;
			out_lin_q   <= lin_d;
			out_ang_q   <= ang_d;
			out_phase_q <= phase_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_drive_q;
	assign m_tdata  = {6'd0, out_phase_q, out_ang_q, out_lin_q};

endmodule

[sv/oes_regs.sv]
// Configuration register file of the obstacle escape sequencer.
// Depends on oes_pkg.
module oes_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [oes_pkg::CFG_ADDR_W-1:0] wr_addr,
	input  logic [oes_pkg::CFG_DATA_W-1:0] wr_data,
	output oes_pkg::cfg_regs_t           regs
);
	import oes_pkg::*;

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.bump_distance_mm <= RST_BUMP_DIST;
			regs_q.robot_size_mm    <= RST_ROBOT_SIZE;
			regs_q.range_min_mm     <= RST_RANGE_MIN;
			regs_q.range_max_mm     <= RST_RANGE_MAX;
			regs_q.backoff_ticks    <= RST_BACK_TICKS;
			regs_q.backoff_speed    <= RST_BACK_SPEED;
			regs_q.turn_ticks       <= RST_TURN_TICKS;
			regs_q.turn_rate        <= RST_TURN_RATE;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_addr))
				REG_BUMP_DIST:  regs_q.bump_distance_mm <= wr_data;
				REG_ROBOT_SIZE: regs_q.robot_size_mm    <= wr_data;
				REG_RANGE_MIN:  regs_q.range_min_mm     <= wr_data;
				REG_RANGE_MAX:  regs_q.range_max_mm     <= wr_data;
				REG_BACK_TICKS: regs_q.backoff_ticks    <= wr_data;
				REG_BACK_SPEED: regs_q.backoff_speed    <= wr_data[SPEED_W-1:0];
				REG_TURN_TICKS: regs_q.turn_ticks       <= wr_data;
				REG_TURN_RATE:  regs_q.turn_rate        <= wr_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule
